// ===== rtl/ccix_pkg.sv =====
// Shared types and constants for the two-circle intersection block.
// No dependencies.
`default_nettype none

package ccix_pkg;

  // Tangent tolerance register
  localparam int TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd16;

  // Result classification
  typedef enum logic [1:0] {
    OUT_NONE       = 2'd0,
    OUT_TANGENT    = 2'd1,
    OUT_CROSS      = 2'd2,
    OUT_COINCIDENT = 2'd3
  } outcome_t;

endpackage

`default_nettype wire

// ===== rtl/ccix_in_if.sv =====
// Request channel carrying one circle pair per item.
// No dependencies.
`default_nettype none

interface ccix_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_center_x;
  logic signed [COORD_WIDTH-1:0] first_center_y;
  logic        [COORD_WIDTH-2:0] first_radius;
  logic signed [COORD_WIDTH-1:0] second_center_x;
  logic signed [COORD_WIDTH-1:0] second_center_y;
  logic        [COORD_WIDTH-2:0] second_radius;

  modport source (
    output valid, first_center_x, first_center_y, first_radius,
           second_center_x, second_center_y, second_radius,
    input  ready
  );

  modport sink (
    input  valid, first_center_x, first_center_y, first_radius,
           second_center_x, second_center_y, second_radius,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/ccix_out_if.sv =====
// Result channel carrying one intersection point per item.
// No dependencies.
`default_nettype none

interface ccix_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic        [1:0]             outcome;
  logic                          last_of_run;

  modport source (
    output valid, point_x, point_y, outcome, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, outcome, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/ccix_sqrt_cell.sv =====
// One root bit of a restoring square root, registered.
// Standalone; chained by the top level.
`default_nettype none

module ccix_sqrt_cell #(
  parameter int NW  = 64,
  parameter int RW  = 32,
  parameter int BIT = 0,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_rem,
  input  logic [RW-1:0] in_root,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_rem,
  output logic [RW-1:0] out_root,
  output logic [SW-1:0] out_side
);

  logic [NW+1:0] trial;
  logic          take;
  logic [NW-1:0] rem_nxt;
  logic [RW-1:0] root_nxt;
  logic          valid_r;
  logic [NW-1:0] rem_r;
  logic [RW-1:0] root_r;
  logic [SW-1:0] side_r;

  // (root + 2^b)^2 - root^2
  assign trial = ({{(NW+2-RW){1'b0}}, in_root} << (BIT + 1))
               + ((NW+2)'(1) << (2 * BIT));
  assign take     = {2'b00, in_rem} >= trial;
  assign rem_nxt  = take ? (in_rem - trial[NW-1:0]) : in_rem;
  assign root_nxt = in_root | (RW'(take) << BIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

// ===== rtl/ccix_div_cell.sv =====
// One quotient bit of restoring division for several lanes sharing a divisor.
// Standalone; chained by the top level.
`default_nettype none

module ccix_div_cell #(
  parameter int NW    = 64,
  parameter int DW    = 32,
  parameter int QW    = 31,
  parameter int LANES = 1,
  parameter int BIT   = 0,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_rem,
  input  logic [DW-1:0]              in_div,
  input  logic [LANES-1:0][QW-1:0]   in_quo,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   out_rem,
  output logic [DW-1:0]              out_div,
  output logic [LANES-1:0][QW-1:0]   out_quo,
  output logic [SW-1:0]              out_side
);

  localparam int CW = NW + DW;

  logic [CW-1:0]              trial;
  logic [LANES-1:0]           take;
  logic [LANES-1:0][NW-1:0]   rem_nxt;
  logic [LANES-1:0][QW-1:0]   quo_nxt;
  logic                       valid_r;
  logic [LANES-1:0][NW-1:0]   rem_r;
  logic [DW-1:0]              div_r;
  logic [LANES-1:0][QW-1:0]   quo_r;
  logic [SW-1:0]              side_r;

  assign trial = {{NW{1'b0}}, in_div} << BIT;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      take[l]    = {{DW{1'b0}}, in_rem[l]} >= trial;
      rem_nxt[l] = take[l] ? (in_rem[l] - trial[NW-1:0]) : in_rem[l];
      quo_nxt[l] = in_quo[l] | (QW'(take[l]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      div_r  <= in_div;
      quo_r  <= quo_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_div   = div_r;
  assign out_quo   = quo_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

// ===== rtl/circle_circle_intersection.sv =====
// Throughput: one circle pair per cycle for single-result outcomes when the output
// is ready; a crossing pair holds the single result port for both of its points.
// Whole pipeline advances together; it stalls only when the output stage holds.
// Reset (sync, active low) empties the pipe; tolerance returns to 16.
// Depends on ccix_pkg, ccix_in_if, ccix_out_if, ccix_sqrt_cell, ccix_div_cell.
`default_nettype none

module circle_circle_intersection
  import ccix_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  ccix_in_if.sink          in_ch,
  ccix_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  localparam int W = COORD_WIDTH;

  // lanes of the final division row
  localparam int LN_AX = 0;  // a*|dx|/d
  localparam int LN_AY = 1;  // a*|dy|/d
  localparam int LN_HX = 2;  // h*|dy|/d, x offset
  localparam int LN_HY = 3;  // h*|dx|/d, y offset

  // Everything an item carries down the chains
  typedef struct packed {
    logic [W-1:0]   x1;
    logic [W-1:0]   y1;
    logic [W-2:0]   r1;
    logic           dx_neg;
    logic           dy_neg;
    logic [W:0]     dx_mag;
    logic [W:0]     dy_mag;
    logic [2*W-3:0] r1sq;
    logic [2*W:0]   nmag;   // |r1^2 + D2 - r2^2|
    logic           aneg;
    logic [W-1:0]   d;
    logic [W-2:0]   a;
    logic [W-2:0]   h;
    logic           none;
    logic           coincident;
  } side_t;

  localparam int SW = $bits(side_t);

  function automatic logic [W-1:0] sat(input logic signed [W+1:0] v);
    logic signed [W+1:0] hi;
    logic signed [W+1:0] lo;
    hi = {3'b000, {(W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[W-1:0];
    end else if (v < lo) begin
      return lo[W-1:0];
    end else begin
      return v[W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  logic adv;       // whole pipe moves
  logic ob_free;
  logic fire;
  logic done;

  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // S0: capture request, center differences
  // ---------------------------------------------------------------------
  logic         s0_valid_r;
  logic [W-1:0] s0_x1_r, s0_y1_r;
  logic [W-2:0] s0_r1_r, s0_r2_r;
  logic [W:0]   s0_dx_r, s0_dy_r;
  logic [W:0]   s0_dx_nxt, s0_dy_nxt;

  assign in_ch.ready = adv;
  assign s0_dx_nxt = {in_ch.second_center_x[W-1], in_ch.second_center_x}
                   - {in_ch.first_center_x[W-1], in_ch.first_center_x};
  assign s0_dy_nxt = {in_ch.second_center_y[W-1], in_ch.second_center_y}
                   - {in_ch.first_center_y[W-1], in_ch.first_center_y};

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x1_r <= in_ch.first_center_x;
      s0_y1_r <= in_ch.first_center_y;
      s0_r1_r <= in_ch.first_radius;
      s0_r2_r <= in_ch.second_radius;
      s0_dx_r <= s0_dx_nxt;
      s0_dy_r <= s0_dy_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // S1: squares
  // ---------------------------------------------------------------------
  logic           s1_valid_r;
  side_t          s1_side_nxt, s1_side_r;
  logic [2*W:0]   s1_dx2_nxt, s1_dy2_nxt, s1_dx2_r, s1_dy2_r;
  logic [2*W-3:0] s1_r2sq_nxt, s1_r2sq_r;
  logic [W-1:0]   s1_sumr;
  logic [2*W-1:0] s1_sumsq_nxt, s1_sumsq_r;

  always_comb begin
    s1_side_nxt        = '0;
    s1_side_nxt.x1     = s0_x1_r;
    s1_side_nxt.y1     = s0_y1_r;
    s1_side_nxt.r1     = s0_r1_r;
    s1_side_nxt.dx_neg = s0_dx_r[W];
    s1_side_nxt.dy_neg = s0_dy_r[W];
    s1_side_nxt.dx_mag = s0_dx_r[W] ? (~s0_dx_r + 1'b1) : s0_dx_r;
    s1_side_nxt.dy_mag = s0_dy_r[W] ? (~s0_dy_r + 1'b1) : s0_dy_r;
    s1_side_nxt.r1sq   = s0_r1_r * s0_r1_r;
    s1_dx2_nxt         = s1_side_nxt.dx_mag * s1_side_nxt.dx_mag;
    s1_dy2_nxt         = s1_side_nxt.dy_mag * s1_side_nxt.dy_mag;
    s1_r2sq_nxt        = s0_r2_r * s0_r2_r;
    s1_sumr            = {1'b0, s0_r1_r} + {1'b0, s0_r2_r};
    s1_sumsq_nxt       = s1_sumr * s1_sumr;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r  <= s1_side_nxt;
      s1_dx2_r   <= s1_dx2_nxt;
      s1_dy2_r   <= s1_dy2_nxt;
      s1_r2sq_r  <= s1_r2sq_nxt;
      s1_sumsq_r <= s1_sumsq_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // S2: D2, reach test, coincident test, r1^2 - r2^2
  // ---------------------------------------------------------------------
  logic           s2_valid_r;
  side_t          s2_side_nxt, s2_side_r;
  logic [2*W+1:0] s2_d2;
  logic [2*W-1:0] s2_d2_r;
  logic [2*W-2:0] s2_rdiff_nxt, s2_rdiff_r;

  always_comb begin
    s2_d2                  = {1'b0, s1_dx2_r} + {1'b0, s1_dy2_r};
    s2_side_nxt            = s1_side_r;
    s2_side_nxt.none       = s2_d2 > {2'b00, s1_sumsq_r};
    s2_side_nxt.coincident = (s2_d2 == '0);
    s2_rdiff_nxt           = {1'b0, s1_side_r.r1sq} - {1'b0, s1_r2sq_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r  <= s2_side_nxt;
      s2_d2_r    <= s2_d2[2*W-1:0];   // below 2^(2W) whenever the pair can meet
      s2_rdiff_r <= s2_rdiff_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // S3: numerator of a, sign and magnitude
  // ---------------------------------------------------------------------
  logic           s3_valid_r;
  side_t          s3_side_nxt, s3_side_r;
  logic [2*W+1:0] s3_num;
  logic [2*W-1:0] s3_d2_r;

  always_comb begin
    s3_num           = {2'b00, s2_d2_r} + {{3{s2_rdiff_r[2*W-2]}}, s2_rdiff_r};
    s3_side_nxt      = s2_side_r;
    s3_side_nxt.aneg = s3_num[2*W+1];
    s3_side_nxt.nmag = s3_num[2*W+1] ? (~s3_num[2*W:0] + 1'b1) : s3_num[2*W:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r <= s3_side_nxt;
      s3_d2_r   <= s2_d2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Root row: d = floor(sqrt(D2)), one bit per cell
  // ---------------------------------------------------------------------
  logic [W:0]                q1_valid;
  logic [W:0][2*W-1:0]       q1_rem;
  logic [W:0][W-1:0]         q1_root;
  logic [W:0][SW-1:0]        q1_side;

  assign q1_valid[0] = s3_valid_r;
  assign q1_rem[0]   = s3_d2_r;
  assign q1_root[0]  = '0;
  assign q1_side[0]  = s3_side_r;

  for (genvar k = 0; k < W; k++) begin : g_sq1
    ccix_sqrt_cell #(
      .NW(2*W), .RW(W), .BIT(W-1-k), .SW(SW)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .in_valid(q1_valid[k]), .in_rem(q1_rem[k]), .in_root(q1_root[k]),
      .in_side(q1_side[k]),
      .out_valid(q1_valid[k+1]), .out_rem(q1_rem[k+1]), .out_root(q1_root[k+1]),
      .out_side(q1_side[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // S4: d known; quotient of a must fit W-1 bits, else one circle is inside
  // ---------------------------------------------------------------------
  logic  s4_valid_r;
  side_t s4_in, s4_side_nxt, s4_side_r;

  always_comb begin
    s4_in            = q1_side[W];
    s4_side_nxt      = s4_in;
    s4_side_nxt.d    = q1_root[W];
    if (s4_in.nmag >= {1'b0, q1_root[W], {W{1'b0}}}) begin
      s4_side_nxt.none = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side_r <= s4_side_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Division row: nmag / (2d)
  // ---------------------------------------------------------------------
  logic [W-1:0]                 da_valid;
  logic [W-1:0][0:0][2*W:0]     da_rem;
  logic [W-1:0][W:0]            da_div;
  logic [W-1:0][0:0][W-2:0]     da_quo;
  logic [W-1:0][SW-1:0]         da_side;

  assign da_valid[0]  = s4_valid_r;
  assign da_rem[0][0] = s4_side_r.nmag;
  assign da_div[0]    = {s4_side_r.d, 1'b0};
  assign da_quo[0]    = '0;
  assign da_side[0]   = s4_side_r;

  for (genvar k = 0; k < W - 1; k++) begin : g_diva
    ccix_div_cell #(
      .NW(2*W+1), .DW(W+1), .QW(W-1), .LANES(1), .BIT(W-2-k), .SW(SW)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .in_valid(da_valid[k]), .in_rem(da_rem[k]), .in_div(da_div[k]),
      .in_quo(da_quo[k]), .in_side(da_side[k]),
      .out_valid(da_valid[k+1]), .out_rem(da_rem[k+1]), .out_div(da_div[k+1]),
      .out_quo(da_quo[k+1]), .out_side(da_side[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // S5: round a (remainder below 2d: half when rem >= d), a > r1 means inside
  // ---------------------------------------------------------------------
  logic         s5_valid_r;
  side_t        s5_in, s5_side_nxt, s5_side_r;
  logic         s5_rup;
  logic [W-1:0] s5_afull;

  always_comb begin
    s5_in       = da_side[W-1];
    s5_rup      = da_rem[W-1][0][W:0] >= {1'b0, s5_in.d};
    s5_afull    = {1'b0, da_quo[W-1][0]} + W'(s5_rup);
    s5_side_nxt = s5_in;
    s5_side_nxt.a = s5_afull[W-2:0];
    if (s5_afull > {1'b0, s5_in.r1}) begin
      s5_side_nxt.none = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side_r <= s5_side_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // S6: r1^2 - a^2
  // ---------------------------------------------------------------------
  logic           s6_valid_r;
  side_t          s6_side_r;
  logic [2*W-3:0] s6_asq;
  logic [2*W-3:0] s6_hsq_nxt, s6_hsq_r;

  assign s6_asq     = s5_side_r.a * s5_side_r.a;
  assign s6_hsq_nxt = s5_side_r.r1sq - s6_asq;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_side_r <= s5_side_r;
      s6_hsq_r  <= s6_hsq_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Root row: half chord h
  // ---------------------------------------------------------------------
  logic [W-1:0]              q2_valid;
  logic [W-1:0][2*W-3:0]     q2_rem;
  logic [W-1:0][W-2:0]       q2_root;
  logic [W-1:0][SW-1:0]      q2_side;

  assign q2_valid[0] = s6_valid_r;
  assign q2_rem[0]   = s6_hsq_r;
  assign q2_root[0]  = '0;
  assign q2_side[0]  = s6_side_r;

  for (genvar k = 0; k < W - 1; k++) begin : g_sq2
    ccix_sqrt_cell #(
      .NW(2*W-2), .RW(W-1), .BIT(W-2-k), .SW(SW)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .in_valid(q2_valid[k]), .in_rem(q2_rem[k]), .in_root(q2_root[k]),
      .in_side(q2_side[k]),
      .out_valid(q2_valid[k+1]), .out_rem(q2_rem[k+1]), .out_root(q2_root[k+1]),
      .out_side(q2_side[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // S7: the four products to be scaled by 1/d (|dx|,|dy| <= d here)
  // ---------------------------------------------------------------------
  logic                   s7_valid_r;
  side_t                  s7_in, s7_side_nxt, s7_side_r;
  logic [3:0][2*W-2:0]    s7_prod_nxt, s7_prod_r;

  always_comb begin
    s7_in              = q2_side[W-1];
    s7_side_nxt        = s7_in;
    s7_side_nxt.h      = q2_root[W-1];
    s7_prod_nxt[LN_AX] = s7_in.a * s7_in.dx_mag[W-1:0];
    s7_prod_nxt[LN_AY] = s7_in.a * s7_in.dy_mag[W-1:0];
    s7_prod_nxt[LN_HX] = q2_root[W-1] * s7_in.dy_mag[W-1:0];
    s7_prod_nxt[LN_HY] = q2_root[W-1] * s7_in.dx_mag[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_side_r <= s7_side_nxt;
      s7_prod_r <= s7_prod_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Division row: four lanes over d
  // ---------------------------------------------------------------------
  logic [W-1:0]                 db_valid;
  logic [W-1:0][3:0][2*W-2:0]   db_rem;
  logic [W-1:0][W-1:0]          db_div;
  logic [W-1:0][3:0][W-2:0]     db_quo;
  logic [W-1:0][SW-1:0]         db_side;

  assign db_valid[0] = s7_valid_r;
  assign db_rem[0]   = s7_prod_r;
  assign db_div[0]   = s7_side_r.d;
  assign db_quo[0]   = '0;
  assign db_side[0]  = s7_side_r;

  for (genvar k = 0; k < W - 1; k++) begin : g_divb
    ccix_div_cell #(
      .NW(2*W-1), .DW(W), .QW(W-1), .LANES(4), .BIT(W-2-k), .SW(SW)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .in_valid(db_valid[k]), .in_rem(db_rem[k]), .in_div(db_div[k]),
      .in_quo(db_quo[k]), .in_side(db_side[k]),
      .out_valid(db_valid[k+1]), .out_rem(db_rem[k+1]), .out_div(db_div[k+1]),
      .out_quo(db_quo[k+1]), .out_side(db_side[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // S8: round terms, base point, offsets, classify
  // ---------------------------------------------------------------------
  logic              s8_valid_r;
  side_t             s8_in;
  logic [3:0][W-2:0] s8_term;
  logic [W:0]        s8_tax, s8_tay;
  logic [W:0]        s8_bx_nxt, s8_by_nxt, s8_bx_r, s8_by_r;
  logic [W-1:0]      s8_ox_nxt, s8_oy_nxt, s8_ox_r, s8_oy_r;
  logic              s8_tangent;
  outcome_t          s8_outcome_nxt, s8_outcome_r;

  always_comb begin
    s8_in = db_side[W-1];
    for (int l = 0; l < 4; l++) begin
      // remainder below d: round half up when 2*rem >= d
      s8_term[l] = db_quo[W-1][l]
                 + (W-1)'({db_rem[W-1][l][W-1:0], 1'b0} >= {1'b0, s8_in.d});
    end
    s8_tax    = {2'b00, s8_term[LN_AX]};
    s8_tay    = {2'b00, s8_term[LN_AY]};
    s8_bx_nxt = {s8_in.x1[W-1], s8_in.x1}
              + ((s8_in.aneg ^ s8_in.dx_neg) ? (~s8_tax + 1'b1) : s8_tax);
    s8_by_nxt = {s8_in.y1[W-1], s8_in.y1}
              + ((s8_in.aneg ^ s8_in.dy_neg) ? (~s8_tay + 1'b1) : s8_tay);
    s8_ox_nxt = s8_in.dy_neg ? (~{1'b0, s8_term[LN_HX]} + 1'b1) : {1'b0, s8_term[LN_HX]};
    s8_oy_nxt = s8_in.dx_neg ? (~{1'b0, s8_term[LN_HY]} + 1'b1) : {1'b0, s8_term[LN_HY]};
    s8_tangent = {{(TOL_W+1){1'b0}}, s8_in.h} <= {{W{1'b0}}, tol_r};
    // coincident first: its d is zero, which also trips the inside test
    priority if (s8_in.coincident) begin
      s8_outcome_nxt = OUT_COINCIDENT;
    end else if (s8_in.none) begin
      s8_outcome_nxt = OUT_NONE;
    end else if (s8_tangent) begin
      s8_outcome_nxt = OUT_TANGENT;
    end else begin
      s8_outcome_nxt = OUT_CROSS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_bx_r      <= s8_bx_nxt;
      s8_by_r      <= s8_by_nxt;
      s8_ox_r      <= s8_ox_nxt;
      s8_oy_r      <= s8_oy_nxt;
      s8_outcome_r <= s8_outcome_nxt;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_ch.valid;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= q1_valid[W];
      s5_valid_r <= da_valid[W-1];
      s6_valid_r <= s5_valid_r;
      s7_valid_r <= q2_valid[W-1];
      s8_valid_r <= db_valid[W-1];
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: holds one item, plays out one or two results
  // ---------------------------------------------------------------------
  logic         ob_valid_r, ob_second_r, ob_two_r;
  outcome_t     ob_outcome_r;
  logic [W-1:0] ob_p1x_r, ob_p1y_r, ob_p2x_r, ob_p2y_r;
  logic [W-1:0] ld_p1x, ld_p1y, ld_p2x, ld_p2y;
  logic         ld_two;
  logic [W+1:0] bx2, by2, ox2, oy2;

  always_comb begin
    bx2    = {s8_bx_r[W], s8_bx_r};
    by2    = {s8_by_r[W], s8_by_r};
    ox2    = {{2{s8_ox_r[W-1]}}, s8_ox_r};
    oy2    = {{2{s8_oy_r[W-1]}}, s8_oy_r};
    ld_p1x = '0;
    ld_p1y = '0;
    ld_p2x = '0;
    ld_p2y = '0;
    ld_two = 1'b0;
    unique case (s8_outcome_r)
      OUT_NONE, OUT_COINCIDENT: begin
        ld_two = 1'b0;
      end
      OUT_TANGENT: begin
        ld_p1x = sat(bx2);
        ld_p1y = sat(by2);
      end
      OUT_CROSS: begin
        ld_two = 1'b1;
        ld_p1x = sat(bx2 - ox2);
        ld_p1y = sat(by2 + oy2);
        ld_p2x = sat(bx2 + ox2);
        ld_p2y = sat(by2 - oy2);
      end
      default: begin
        ld_two = 1'b0;
      end
    endcase
  end

  assign fire    = ob_valid_r && out_ch.ready;
  assign done    = fire && (!ob_two_r || ob_second_r);
  assign ob_free = !ob_valid_r || done;
  assign adv     = !s8_valid_r || ob_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r  <= 1'b0;
      ob_second_r <= 1'b0;
    end else if (s8_valid_r && ob_free) begin
      ob_valid_r  <= 1'b1;
      ob_second_r <= 1'b0;
    end else if (done) begin
      ob_valid_r  <= 1'b0;
      ob_second_r <= 1'b0;
    end else if (fire) begin
      ob_second_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s8_valid_r && ob_free) begin
      ob_two_r     <= ld_two;
      ob_outcome_r <= s8_outcome_r;
      ob_p1x_r     <= ld_p1x;
      ob_p1y_r     <= ld_p1y;
      ob_p2x_r     <= ld_p2x;
      ob_p2y_r     <= ld_p2y;
    end
  end

  assign out_ch.valid       = ob_valid_r;
  assign out_ch.point_x     = ob_second_r ? ob_p2x_r : ob_p1x_r;
  assign out_ch.point_y     = ob_second_r ? ob_p2y_r : ob_p1y_r;
  assign out_ch.outcome     = ob_outcome_r;
  assign out_ch.last_of_run = !ob_two_r || ob_second_r;

`ifndef SYNTHESIS
  a_second_only_for_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    ob_second_r |-> (ob_two_r && ob_valid_r))
    else $error("second result flagged on a single-result item");

  a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !done) |=> (ob_valid_r && ob_second_r))
    else $error("second point did not follow the first");

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(s8_valid_r) && $stable(s8_bx_r) && $stable(s8_outcome_r)))
    else $error("pipe tail moved while stalled");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.outcome != OUT_CROSS) |-> out_ch.last_of_run)
    else $error("single result not marked last");

  a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.outcome == OUT_COINCIDENT)
      |-> (out_ch.point_x == '0 && out_ch.point_y == '0))
    else $error("coincident result carries a point");
`endif

endmodule

`default_nettype wire
